// ----- rtl/shsq_pkg.sv -----
// Shared types, constants and the coil pattern table of the half-step sequencer.
package shsq_pkg;

	localparam int SPR_W       = 13;
	localparam int HOLD_W      = 8;
	localparam int ANGLE_W     = 16;
	localparam int DUR_W       = 16;
	localparam int STEPS_W     = 16;
	localparam int TICK_W      = 17;
	localparam int COIL_W      = 4;
	localparam int PROD_W      = ANGLE_W + SPR_W;
	localparam int DIV_W       = DUR_W;
	localparam int DEN_W       = 16;
	localparam int CNT_W       = 5;
	localparam int CFG_W       = SPR_W;

	// 360 degrees per revolution is 45 << 3. The product is shifted down by three and then
	// multiplied by ceil(2^31 / 45), which gives the exact quotient for every 26-bit value.
	localparam int DEG_ODD     = 45;
	localparam int DEG_SHIFT   = 3;
	localparam int RCP_W       = PROD_W - DEG_SHIFT;
	localparam int RCP_SHIFT   = 31;
	localparam int QUO_W       = 2 * RCP_W - RCP_SHIFT;

	localparam logic [SPR_W-1:0]  SPR_RESET   = SPR_W'(512);
	localparam logic [HOLD_W-1:0] HOLD_RESET  = HOLD_W'(5);
	localparam logic [RCP_W-1:0]  DEG_RECIP   =
		RCP_W'(((64'd1 << RCP_SHIFT) + 64'(DEG_ODD - 1)) / 64'(DEG_ODD));
	localparam logic [CNT_W-1:0]  DIV2_ITERS  = CNT_W'(DUR_W);
	localparam logic [2:0]        LAST_PHASE  = 3'd7;

	typedef enum logic {
		REQ_TICK  = 1'b0,
		REQ_START = 1'b1
	} req_t;

	typedef enum logic {
		CFG_STEPS_PER_REV = 1'b0,
		CFG_PHASE_HOLD    = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_TICK  = 2'd0,
		ST_START = 2'd1,
		ST_BUSY  = 2'd2,
		ST_ZERO  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_MUL,
		S_RECIP,
		S_SAT,
		S_DIV2_GO,
		S_DIV2_WAIT,
		S_REPLY
	} state_t;

	typedef struct packed {
		logic               start;
		logic [DIV_W-1:0]   num;
		logic [DEN_W-1:0]   den;
		logic [CNT_W-1:0]   iters;
	} div_req_t;

	typedef struct packed {
		logic active;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic               tick;
		logic               start;
		logic [STEPS_W-1:0] steps;
		logic [DUR_W-1:0]   pause;
		logic               dir;
	} motion_cmd_t;

	typedef struct packed {
		logic [COIL_W-1:0] coils;
		logic              running;
	} motion_stat_t;

	// Clockwise half-step order; anticlockwise walks the same list backwards.
	function automatic logic [COIL_W-1:0] pattern_for(input logic dir, input logic [2:0] idx);
		logic [2:0] i;
		logic [COIL_W-1:0] p;
		i = dir ? (3'd7 - idx) : idx;
		case (i)
			3'd0: p = 4'b1000;
			3'd1: p = 4'b1100;
			3'd2: p = 4'b0100;
			3'd3: p = 4'b0110;
			3'd4: p = 4'b0010;
			3'd5: p = 4'b0011;
			3'd6: p = 4'b0001;
			default: p = 4'b1001;
		endcase
		return p;
	endfunction

endpackage

// ----- rtl/shsq_divider.sv -----
// Restoring serial divider, one quotient bit per cycle.
module shsq_divider import shsq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output div_stat_t        stat,
	output logic [DIV_W-1:0] quot
);

	logic [DIV_W-1:0] work_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             active_q;
	logic             done_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] diff;
	logic             ge;

	assign shifted = {rem_q[DEN_W-1:0], work_q[DIV_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign ge      = !diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else if (req.start) begin
			active_q <= 1'b1;
			done_q   <= 1'b0;
			cnt_q    <= req.iters;
		end else if (active_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				active_q <= 1'b0;
				done_q   <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.num;
			rem_q  <= '0;
			den_q  <= req.den;
		end else if (active_q) begin
			work_q <= {work_q[DIV_W-2:0], ge};
			rem_q  <= ge ? diff[DEN_W:0] : shifted;
		end
	end

	assign stat.active = active_q;
	assign stat.done   = done_q;
	assign quot        = work_q;

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> cnt_q != '0) else $error("divider active with zero count");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q || $past(req.start, 1) == 1'b0 && !done_q)
		else $error("divider done held");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !active_q) else $error("divider done while active");

endmodule

// ----- rtl/shsq_motion.sv -----
// Step, phase and hold-time state of the coil drive.
module shsq_motion import shsq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [HOLD_W-1:0] phase_hold,
	input  motion_cmd_t       cmd,
	output motion_stat_t      stat
);

	logic [STEPS_W-1:0] steps_left_q;
	logic [2:0]         phase_q;
	logic [TICK_W-1:0]  tick_count_q;
	logic [DUR_W-1:0]   step_pause_q;
	logic               turn_dir_q;
	logic               running_q;
	logic [COIL_W-1:0]  coils_q;

	logic [TICK_W-1:0]  hold;
	logic [TICK_W-1:0]  tick_inc;
	logic [STEPS_W-1:0] steps_dec;
	logic               is_last;

	assign is_last   = (phase_q == LAST_PHASE);
	assign hold      = TICK_W'(phase_hold) + (is_last ? TICK_W'(step_pause_q) : '0);
	assign tick_inc  = tick_count_q + TICK_W'(1);
	assign steps_dec = steps_left_q - STEPS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_left_q <= '0;
			phase_q      <= '0;
			tick_count_q <= '0;
			step_pause_q <= '0;
			turn_dir_q   <= 1'b0;
			running_q    <= 1'b0;
			coils_q      <= '0;
		end else if (cmd.start) begin
			steps_left_q <= cmd.steps;
			step_pause_q <= cmd.pause;
			turn_dir_q   <= cmd.dir;
			phase_q      <= '0;
			tick_count_q <= '0;
			running_q    <= 1'b1;
			coils_q      <= pattern_for(cmd.dir, 3'd0);
		end else if (cmd.tick && running_q) begin
			if (tick_inc >= hold) begin
				tick_count_q <= '0;
				if (is_last) begin
					steps_left_q <= steps_dec;
					if (steps_dec == '0) begin
						running_q <= 1'b0;
					end else begin
						phase_q <= '0;
						coils_q <= pattern_for(turn_dir_q, 3'd0);
					end
				end else begin
					phase_q <= phase_q + 3'd1;
					coils_q <= pattern_for(turn_dir_q, phase_q + 3'd1);
				end
			end else begin
				tick_count_q <= tick_inc;
			end
		end
	end

	assign stat.coils   = coils_q;
	assign stat.running = running_q;

endmodule

// ----- rtl/stepper_half_step_sequencer.sv -----
// Top level of the unipolar stepper half-step sequencer: control sequencer and ports.
//
// Every input item gives exactly one result. A tick, and a start refused while busy,
// pass through decode and then the reply state. A start first multiplies angle by
// steps_per_rev, then turns that into the step count by a reciprocal multiplication for
// the division by 360, then saturates it, and then, unless the step count is zero, the
// serial divider divides duration_ms by the step count for the per-step pause. in_stall
// is high while the sequencer works on an item and drops in the same cycle that out_valid
// rises, so the next item can be taken from then on; a result held by out_stall only
// holds back the result of the next item.
// Register writes take effect at once.
module stepper_half_step_sequencer import shsq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [ANGLE_W-1:0] angle_deg,
	input  logic               direction,
	input  logic [DUR_W-1:0]   duration_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [COIL_W-1:0]  coil_pattern,
	output logic               busy_res,
	output logic [1:0]         status
);

	state_t state_q, state_d;

	logic [SPR_W-1:0]   spr_q;
	logic [HOLD_W-1:0]  hold_q;

	req_t               req_q;
	logic [ANGLE_W-1:0] angle_q;
	logic               dir_q;
	logic [DUR_W-1:0]   dur_q;
	logic [PROD_W-1:0]  product_q;
	logic [QUO_W-1:0]   quo_q;
	logic [STEPS_W-1:0] steps_q;
	status_t            status_q;

	logic               out_valid_q;
	logic [COIL_W-1:0]  coil_q;
	logic               busy_q;
	status_t            out_status_q;

	logic               in_xfer;
	logic               reply_go;
	logic               status_load;
	status_t            status_d;
	logic [STEPS_W-1:0] steps_sat;
	logic [2*RCP_W-1:0] recip_prod;

	div_req_t           div_req;
	div_stat_t          div_stat;
	logic [DIV_W-1:0]   div_quot;
	motion_cmd_t        mcmd;
	motion_stat_t       mstat;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;

	// The result register is free when empty or when its transfer happens this cycle.
	assign reply_go = (state_q == S_REPLY) && (!out_valid_q || !out_stall);

	assign recip_prod = (2*RCP_W)'(product_q[PROD_W-1:DEG_SHIFT]) * (2*RCP_W)'(DEG_RECIP);

	// Step count saturates at the top of its field.
	assign steps_sat = (|quo_q[QUO_W-1:STEPS_W]) ? '1 : quo_q[STEPS_W-1:0];

	shsq_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	shsq_motion u_motion (
		.clk        (clk),
		.arst_n     (arst_n),
		.phase_hold (hold_q),
		.cmd        (mcmd),
		.stat       (mstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q  <= SPR_RESET;
			hold_q <= HOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_STEPS_PER_REV: spr_q  <= cfg_data;
				CFG_PHASE_HOLD:    hold_q <= cfg_data[HOLD_W-1:0];
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:      if (in_xfer) state_d = S_DECODE;
			S_DECODE: begin
				if (req_q == REQ_TICK || mstat.running) state_d = S_REPLY;
				else state_d = S_MUL;
			end
			S_MUL:       state_d = S_RECIP;
			S_RECIP:     state_d = S_SAT;
			S_SAT:       state_d = (steps_sat == '0) ? S_REPLY : S_DIV2_GO;
			S_DIV2_GO:   state_d = S_DIV2_WAIT;
			S_DIV2_WAIT: if (div_stat.done) state_d = S_REPLY;
			S_REPLY:     if (!out_valid_q || !out_stall) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		div_req     = '0;
		mcmd        = '0;
		status_load = 1'b0;
		status_d    = ST_TICK;
		mcmd.steps  = steps_q;
		mcmd.pause  = div_quot[DUR_W-1:0];
		mcmd.dir    = dir_q;
		unique case (state_q)
			S_DECODE: begin
				status_load = 1'b1;
				if (req_q == REQ_TICK) begin
					mcmd.tick = 1'b1;
					status_d  = ST_TICK;
				end else begin
					status_d  = ST_BUSY;
				end
			end
			S_SAT: begin
				status_load = 1'b1;
				status_d    = ST_ZERO;
			end
			S_DIV2_GO: begin
				div_req.start = 1'b1;
				div_req.num   = dur_q;
				div_req.den   = steps_q;
				div_req.iters = DIV2_ITERS;
			end
			S_DIV2_WAIT: begin
				if (div_stat.done) begin
					mcmd.start  = 1'b1;
					status_load = 1'b1;
					status_d    = ST_START;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (reply_go) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q   <= req_t'(req_type);
			angle_q <= angle_deg;
			dir_q   <= direction;
			dur_q   <= duration_ms;
		end
		if (state_q == S_MUL) begin
			product_q <= {{SPR_W{1'b0}}, angle_q} * {{ANGLE_W{1'b0}}, spr_q};
		end
		if (state_q == S_RECIP) begin
			quo_q <= recip_prod[2*RCP_W-1:RCP_SHIFT];
		end
		if (state_q == S_SAT) begin
			steps_q <= steps_sat;
		end
		if (status_load) begin
			status_q <= status_d;
		end
		if (reply_go) begin
			coil_q       <= mstat.coils;
			busy_q       <= mstat.running;
			out_status_q <= status_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign coil_pattern = coil_q;
	assign busy_res     = busy_q;
	assign status       = out_status_q;

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_status_q))
		else $error("stalled result dropped or changed");
	a_xfer_decode: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == S_DECODE) else $error("transfer not followed by decode");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == S_DIV2_WAIT)
		else $error("divider finished outside a wait state");

endmodule
